@@ rtl/ssb_pkg.sv @@
// ============================================================================
// ssb_pkg - shared types and constants for the scaled sprite blitter
// Register map, configuration record, queue entry and clamp helpers.
// ============================================================================
`default_nettype none

package ssb_pkg;

    localparam int MAX_SPRITE_DIM = 64;
    localparam int MAX_SCALE      = 8;
    localparam int MAX_SCREEN_DIM = 1024;

    localparam int COLOR_W = 16;
    localparam int POS_W   = 11;                       // dest_x / dest_y
    localparam int DIM_W   = 7;                        // sprite_width / height
    localparam int SCALE_W = 4;
    localparam int SCR_W   = 10;                       // framebuffer width / height
    localparam int ADDR_W  = 20;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = POS_W;                    // widest register
    localparam int CNT_W   = $clog2(MAX_SPRITE_DIM);   // column / row counters
    localparam int STEP_W  = $clog2(MAX_SCALE);        // dx / dy counters
    localparam int OFF_W   = CNT_W + SCALE_W;          // col * scale
    localparam int COORD_W = 13;                       // signed screen coordinate

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [IDX_W-1:0] {
        REG_DEST_X        = 3'd0,
        REG_DEST_Y        = 3'd1,
        REG_SPRITE_WIDTH  = 3'd2,
        REG_SPRITE_HEIGHT = 3'd3,
        REG_SCALE_FACTOR  = 3'd4,
        REG_FB_WIDTH      = 3'd5,
        REG_FB_HEIGHT     = 3'd6
    } ssb_reg_t;

    typedef struct packed {
        logic [POS_W-1:0]   dest_x;
        logic [POS_W-1:0]   dest_y;
        logic [DIM_W-1:0]   sprite_width;
        logic [DIM_W-1:0]   sprite_height;
        logic [SCALE_W-1:0] scale_factor;
        logic [SCR_W-1:0]   fb_width;
        logic [SCR_W-1:0]   fb_height;
    } ssb_cfg_t;

    localparam ssb_cfg_t CFG_RESET = '{
        dest_x:        POS_W'(0),
        dest_y:        POS_W'(0),
        sprite_width:  DIM_W'(1),
        sprite_height: DIM_W'(1),
        scale_factor:  SCALE_W'(1),
        fb_width:      SCR_W'(205),
        fb_height:     SCR_W'(120)
    };

    // one source pixel, already placed on screen at its block's top-left corner
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [COORD_W-1:0] px0;
        logic [COORD_W-1:0] py0;
        logic               last_pixel;
    } ssb_job_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_SPRITE_DIM))
            r = DIM_W'(MAX_SPRITE_DIM);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] v);
        logic [SCALE_W-1:0] r;
        if (v == '0)
            r = SCALE_W'(1);
        else if (v > SCALE_W'(MAX_SCALE))
            r = SCALE_W'(MAX_SCALE);
        else
            r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ssb_if.sv @@
// ============================================================================
// ssb_if - channel interfaces of the scaled sprite blitter
// Pixel input channel and framebuffer write channel, valid/ready.
// ============================================================================
`default_nettype none

interface ssb_pix_if import ssb_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_color;

    modport source (output valid, output pixel_color, input ready);
    modport sink   (input valid, input pixel_color, output ready);
endinterface

interface ssb_wr_if import ssb_pkg::*;;
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  fb_address;
    logic [COLOR_W-1:0] write_color;
    logic               in_bounds;
    logic               last_of_block;
    logic               last_of_sprite;

    modport source (output valid, output fb_address, output write_color,
                    output in_bounds, output last_of_block, output last_of_sprite,
                    input ready);
    modport sink   (input valid, input fb_address, input write_color,
                    input in_bounds, input last_of_block, input last_of_sprite,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/scaled_sprite_blitter_core.sv @@
// ============================================================================
// scaled_sprite_blitter_core - integer scaled sprite blit with clipping
// Turns a row-major stream of sprite pixels into framebuffer writes.
// ============================================================================
// Usage:
//   pix : sprite pixels (RGB565) in row-major order, valid/ready.
//   wr  : framebuffer writes, valid/ready. Each pixel gives scale*scale beats,
//         dy outer, dx inner. Off-screen beats come out with in_bounds low
//         and address zero. last_of_block marks a pixel's final beat,
//         last_of_sprite the final beat of the sprite.
//   cfg : write enable, register index, data. Write only while idle.
// Path: an accepted pixel is held in the queue, then in the job register,
//   and its first write beat is registered in the output register.
// Throughput: the write generator emits one beat per cycle while the write
//   side is ready, scale*scale beats (1 to 64) per pixel; blocks follow with no gap.
// A two-entry job queue lets intake run ahead while writes are stalled;
//   when the queue is full pix.ready drops. A stalled beat holds in the
//   output register and generation pauses.
// Reset: position counters to the sprite's first pixel, registers to their
//   defaults (205 x 120 screen, 1 x 1 sprite, scale 1 at origin).
// ============================================================================
`default_nettype none

module scaled_sprite_blitter_core import ssb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    ssb_pix_if.sink               pix,
    ssb_wr_if.source              wr
);

    ssb_cfg_t cfg_reg, cfg_next;
    logic     q_push_valid, q_push_ready;
    logic     q_pop_valid, q_pop_ready;
    ssb_job_t q_push_data, q_pop_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEST_X:        cfg_next.dest_x        = cfg_data[POS_W-1:0];
                REG_DEST_Y:        cfg_next.dest_y        = cfg_data[POS_W-1:0];
                REG_SPRITE_WIDTH:  cfg_next.sprite_width  = cfg_data[DIM_W-1:0];
                REG_SPRITE_HEIGHT: cfg_next.sprite_height = cfg_data[DIM_W-1:0];
                REG_SCALE_FACTOR:  cfg_next.scale_factor  = cfg_data[SCALE_W-1:0];
                REG_FB_WIDTH:      cfg_next.fb_width      = cfg_data[SCR_W-1:0];
                REG_FB_HEIGHT:     cfg_next.fb_height     = cfg_data[SCR_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    ssb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pix        (pix),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data)
    );

    ssb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    ssb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_data  (q_pop_data),
        .wr        (wr)
    );

    a_sprite_end_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        wr.valid && wr.last_of_sprite |-> wr.last_of_block)
        else $error("last_of_sprite without last_of_block");

    a_clipped_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        wr.valid && !wr.in_bounds |-> wr.fb_address == '0)
        else $error("clipped write carries an address");

    a_stall_holds_beat: assert property (@(posedge clk) disable iff (!rst_n)
        wr.valid && !wr.ready |=> wr.valid && $stable({wr.fb_address, wr.write_color,
            wr.in_bounds, wr.last_of_block, wr.last_of_sprite}))
        else $error("write beat changed while stalled");

endmodule

`default_nettype wire

@@ rtl/ssb_front.sv @@
// ============================================================================
// ssb_front - pixel intake
// Tracks source column/row, flags the sprite's last pixel and places the
// pixel's block on screen before handing it to the queue.
// ============================================================================
`default_nettype none

module ssb_front import ssb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ssb_cfg_t  cfg,
    ssb_pix_if.sink        pix,
    output logic           push_valid,
    input  wire logic      push_ready,
    output ssb_job_t       push_data
);

    logic [CNT_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   row_reg, row_next;
    logic [DIM_W-1:0]   w, h;
    logic [SCALE_W-1:0] s;
    logic               restart;
    logic [CNT_W-1:0]   c, r;
    logic [DIM_W-1:0]   col_inc, row_inc;
    logic [OFF_W-1:0]   col_off, row_off;
    logic [COORD_W-1:0] x_ext, y_ext;
    logic               take;

    assign w = clamp_dim(cfg.sprite_width);
    assign h = clamp_dim(cfg.sprite_height);
    assign s = clamp_scale(cfg.scale_factor);

    assign pix.ready  = push_ready;
    assign push_valid = pix.valid;
    assign take       = pix.valid && push_ready;

    // counters left beyond a shrunk sprite start a new sprite
    assign restart = (DIM_W'(col_reg) >= w) || (DIM_W'(row_reg) >= h);
    assign c       = restart ? '0 : col_reg;
    assign r       = restart ? '0 : row_reg;
    assign col_inc = DIM_W'(c) + DIM_W'(1);
    assign row_inc = DIM_W'(r) + DIM_W'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (take)
        begin
            if (col_inc >= w)
            begin
                col_next = '0;
                row_next = (row_inc >= h) ? '0 : row_inc[CNT_W-1:0];
            end
            else
            begin
                col_next = col_inc[CNT_W-1:0];
                row_next = r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col_off = OFF_W'(c) * OFF_W'(s);
    assign row_off = OFF_W'(r) * OFF_W'(s);
    assign x_ext   = {{(COORD_W-POS_W){cfg.dest_x[POS_W-1]}}, cfg.dest_x};
    assign y_ext   = {{(COORD_W-POS_W){cfg.dest_y[POS_W-1]}}, cfg.dest_y};

    always_comb
    begin
        push_data.color      = pix.pixel_color;
        push_data.px0        = x_ext + COORD_W'(col_off);
        push_data.py0        = y_ext + COORD_W'(row_off);
        push_data.last_pixel = (DIM_W'(c) == w - DIM_W'(1)) && (DIM_W'(r) == h - DIM_W'(1));
    end

endmodule

`default_nettype wire

@@ rtl/ssb_queue.sv @@
// ============================================================================
// ssb_queue - short job queue
// Register FIFO between pixel intake and write generation.
// ============================================================================
`default_nettype none

module ssb_queue import ssb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_valid,
    output logic           push_ready,
    input  wire ssb_job_t  push_data,
    output logic           pop_valid,
    input  wire logic      pop_ready,
    output ssb_job_t       pop_data
);

    ssb_job_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push, pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // depth is a power of two: pointers wrap on their own
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

@@ rtl/ssb_back.sv @@
// ============================================================================
// ssb_back - write generator
// Walks the scale x scale block of one job, one framebuffer write per beat,
// clips against the screen and drives the registered write channel.
// ============================================================================
`default_nettype none

module ssb_back import ssb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ssb_cfg_t  cfg,
    input  wire logic      pop_valid,
    output logic           pop_ready,
    input  wire ssb_job_t  pop_data,
    ssb_wr_if.source       wr
);

    ssb_job_t           job_reg;
    logic               busy_reg, busy_next;
    logic [STEP_W-1:0]  dx_reg, dx_next;
    logic [STEP_W-1:0]  dy_reg, dy_next;

    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               inb_reg, lastb_reg, lasts_reg;

    logic [SCALE_W-1:0] s, s_m1;
    logic               emit, last_b, load;
    logic [COORD_W-1:0] px, py;
    logic               inb;
    logic [ADDR_W-1:0]  row_base, addr;

    assign s      = clamp_scale(cfg.scale_factor);
    assign s_m1   = s - SCALE_W'(1);
    assign last_b = (dx_reg == s_m1[STEP_W-1:0]) && (dy_reg == s_m1[STEP_W-1:0]);
    assign emit   = busy_reg && (!out_valid_reg || wr.ready);

    // next job enters on the beat that finishes the current block
    assign pop_ready = !busy_reg || (emit && last_b);
    assign load      = pop_valid && pop_ready;

    assign px  = job_reg.px0 + COORD_W'(dx_reg);
    assign py  = job_reg.py0 + COORD_W'(dy_reg);
    assign inb = !px[COORD_W-1] && !py[COORD_W-1]
              && (px < COORD_W'(cfg.fb_width))
              && (py < COORD_W'(cfg.fb_height));

    assign row_base = ADDR_W'(py[SCR_W-1:0]) * ADDR_W'(cfg.fb_width);
    assign addr     = row_base + ADDR_W'(px[SCR_W-1:0]);

    always_comb
    begin
        busy_next = busy_reg;
        dx_next   = dx_reg;
        dy_next   = dy_reg;
        if (load)
        begin
            busy_next = 1'b1;
            dx_next   = '0;
            dy_next   = '0;
        end
        else if (emit)
        begin
            if (last_b)
                busy_next = 1'b0;
            if (dx_reg == s_m1[STEP_W-1:0])
            begin
                dx_next = '0;
                dy_next = dy_reg + STEP_W'(1);
            end
            else
            begin
                dx_next = dx_reg + STEP_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (wr.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            job_reg <= pop_data;
        if (emit)
        begin
            addr_reg  <= inb ? addr : '0;
            color_reg <= job_reg.color;
            inb_reg   <= inb;
            lastb_reg <= last_b;
            lasts_reg <= last_b && job_reg.last_pixel;
        end
    end

    assign wr.valid          = out_valid_reg;
    assign wr.fb_address     = addr_reg;
    assign wr.write_color    = color_reg;
    assign wr.in_bounds      = inb_reg;
    assign wr.last_of_block  = lastb_reg;
    assign wr.last_of_sprite = lasts_reg;

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench - regression for scaled_sprite_blitter_core
// Drives sprite pixels and register writes, predicts every framebuffer write
// beat from its own model of the blitter and compares each beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import ssb_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [IDX_W-1:0] UNUSED_INDEX = 3'd7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    typedef struct packed {
        logic [ADDR_W-1:0]  fb_address;
        logic [COLOR_W-1:0] write_color;
        logic               in_bounds;
        logic               last_of_block;
        logic               last_of_sprite;
    } fb_write_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    ssb_pix_if pix_ch();
    ssb_wr_if  wr_ch();

    scaled_sprite_blitter_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix_ch),
        .wr        (wr_ch)
    );

    // blitter model: register copies and source position
    logic signed [POS_W-1:0] m_dest_x;
    logic signed [POS_W-1:0] m_dest_y;
    logic [DIM_W-1:0]        m_width;
    logic [DIM_W-1:0]        m_height;
    logic [SCALE_W-1:0]      m_scale;
    logic [SCR_W-1:0]        m_scr_w;
    logic [SCR_W-1:0]        m_scr_h;
    int                      src_col;
    int                      src_row;

    fb_write_t pending_writes[$];

    int send_idle_pct  = 0;
    int sink_stall_pct = 0;
    int idle_cycles    = 0;
    int errors         = 0;
    int n_pixels       = 0;
    int n_beats        = 0;
    int n_onscreen     = 0;
    int n_sprite_ends  = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int dim_used(input logic [DIM_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_SPRITE_DIM)
            return MAX_SPRITE_DIM;
        return int'(v);
    endfunction

    function automatic int scale_used(input logic [SCALE_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_SCALE)
            return MAX_SCALE;
        return int'(v);
    endfunction

    // expands one pixel into its scale x scale block of writes, dy outer
    task automatic blit_pixel(input logic [COLOR_W-1:0] color);
        int        w;
        int        h;
        int        s;
        int        sw;
        int        sh;
        int        x0;
        int        y0;
        int        px;
        int        py;
        bit        last_pixel;
        bit        inb;
        bit        lob;
        fb_write_t e;
        w  = dim_used(m_width);
        h  = dim_used(m_height);
        s  = scale_used(m_scale);
        sw = (m_scr_w > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : int'(m_scr_w);
        sh = (m_scr_h > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : int'(m_scr_h);
        x0 = m_dest_x;
        y0 = m_dest_y;
        // sprite shrank under the counters: start a new sprite
        if (src_col >= w || src_row >= h)
        begin
            src_col = 0;
            src_row = 0;
        end
        last_pixel = (src_col == w - 1) && (src_row == h - 1);
        for (int dy = 0; dy < s; dy++)
        begin
            for (int dx = 0; dx < s; dx++)
            begin
                px  = x0 + src_col * s + dx;
                py  = y0 + src_row * s + dy;
                inb = (px >= 0) && (py >= 0) && (px < sw) && (py < sh);
                lob = (dx == s - 1) && (dy == s - 1);
                e.fb_address     = inb ? ADDR_W'(py * sw + px) : '0;
                e.write_color    = color;
                e.in_bounds      = inb;
                e.last_of_block  = lob;
                e.last_of_sprite = lob && last_pixel;
                pending_writes.push_back(e);
            end
        end
        src_col++;
        if (src_col >= w)
        begin
            src_col = 0;
            src_row++;
            if (src_row >= h)
                src_row = 0;
        end
        n_pixels++;
    endtask

    // valid stays high after the beat; settle() or an idle gap before the next pixel drops it
    task automatic send_pixel(input logic [COLOR_W-1:0] color);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_color <= color;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        blit_pixel(color);
    endtask

    task automatic send_pixels(input int n);
        for (int i = 0; i < n; i++)
            send_pixel(COLOR_W'($urandom_range(0, 65535)));
    endtask

    task automatic settle();
        @(negedge clk);
        pix_ch.valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_reg(input logic [IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        case (idx)
            REG_DEST_X:        m_dest_x = POS_W'(value);
            REG_DEST_Y:        m_dest_y = POS_W'(value);
            REG_SPRITE_WIDTH:  m_width  = DIM_W'(value);
            REG_SPRITE_HEIGHT: m_height = DIM_W'(value);
            REG_SCALE_FACTOR:  m_scale  = SCALE_W'(value);
            REG_FB_WIDTH:      m_scr_w  = SCR_W'(value);
            REG_FB_HEIGHT:     m_scr_h  = SCR_W'(value);
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input int x, input int y, input int w, input int h,
                             input int s, input int sw, input int sh);
        set_reg(REG_DEST_X, x);
        set_reg(REG_DEST_Y, y);
        set_reg(REG_SPRITE_WIDTH, w);
        set_reg(REG_SPRITE_HEIGHT, h);
        set_reg(REG_SCALE_FACTOR, s);
        set_reg(REG_FB_WIDTH, sw);
        set_reg(REG_FB_HEIGHT, sh);
        end_writes();
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_writes
        fb_write_t got;
        fb_write_t want;
        if (rst_n && wr_ch.valid && wr_ch.ready)
        begin
            got.fb_address     = wr_ch.fb_address;
            got.write_color    = wr_ch.write_color;
            got.in_bounds      = wr_ch.in_bounds;
            got.last_of_block  = wr_ch.last_of_block;
            got.last_of_sprite = wr_ch.last_of_sprite;
            if (pending_writes.size() == 0)
            begin
                errors++;
                $display("%0t: write beat with nothing expected, expected none actual %h",
                         $time, got);
            end
            else
            begin
                want = pending_writes.pop_front();
                check_field("fb_address", want.fb_address, got.fb_address);
                check_field("write_color", want.write_color, got.write_color);
                check_field("in_bounds", want.in_bounds, got.in_bounds);
                check_field("last_of_block", want.last_of_block, got.last_of_block);
                check_field("last_of_sprite", want.last_of_sprite, got.last_of_sprite);
            end
            n_beats++;
            if (got.in_bounds)
                n_onscreen++;
            if (got.last_of_sprite)
                n_sprite_ends++;
        end
    end

    initial
    begin
        wr_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            wr_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (pix_ch.valid && pix_ch.ready) || (wr_ch.valid && wr_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles < WATCHDOG_LIMIT)
            idle_cycles <= idle_cycles + 1;
        else
        begin
            $display("%0t: no beat for %0d cycles, %0d writes outstanding",
                     $time, WATCHDOG_LIMIT, pending_writes.size());
            $display("scaled_sprite_blitter_core regression: fail");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        // 1x1 sprite at the origin: every pixel closes a sprite
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        settle();
    endtask

    task automatic test_size_clamps();
        // zero sizes and zero scale act as one
        configure(5, 7, 0, 0, 0, 205, 120);
        send_pixel(16'h1234);
        settle();
        // oversize width acts as 64, scale 15 as 8
        configure(-4, 2, 127, 0, 15, 205, 120);
        send_pixels(2);
        settle();
    endtask

    task automatic test_screen_edges();
        configure(-1024, 1023, 2, 2, MAX_SCALE, 1023, 1023);
        send_pixels(4);
        settle();
        // top of the address range, block half clipped on both axes
        configure(1022, 1022, 1, 1, 2, 1023, 1023);
        send_pixel(16'hFFFF);
        settle();
        configure(-3, -3, 2, 1, 4, 5, 5);
        send_pixels(2);
        settle();
        configure(0, 0, 2, 1, 2, 0, 120);
        send_pixels(2);
        settle();
        configure(0, 0, 2, 1, 2, 205, 0);
        send_pixels(2);
        settle();
    endtask

    task automatic test_counter_restart();
        configure(10, 10, 4, 4, 1, 205, 120);
        send_pixels(6);
        settle();
        // column 2 is past the new width
        configure(10, 10, 2, 4, 1, 205, 120);
        send_pixels(3);
        settle();
        // row 1 is past the new height
        configure(10, 10, 2, 1, 1, 205, 120);
        send_pixels(2);
        settle();
    endtask

    task automatic test_ignored_index();
        configure(20, 30, 1, 1, 3, 205, 120);
        set_reg(UNUSED_INDEX, 11'h7FF);
        end_writes();
        send_pixel(16'hA5A5);
        settle();
    endtask

    task automatic test_long_rows(input int idle, input int stall);
        send_idle_pct  = idle;
        sink_stall_pct = stall;
        configure(-5, 100, MAX_SPRITE_DIM, 1, 1, 50, 120);
        send_pixels(MAX_SPRITE_DIM);
        settle();
        configure(3, -2, 1, MAX_SPRITE_DIM, 1, 205, 40);
        send_pixels(MAX_SPRITE_DIM);
        settle();
    endtask

    // random registers, mostly small sprites and scales; upper data bits are junk
    task automatic random_setup();
        int r;
        int s_raw;
        int w_raw;
        int h_raw;
        int sw;
        int sh;
        int x;
        int y;
        r = $urandom_range(99);
        if (r < 5)
            s_raw = 0;
        else if (r < 10)
            s_raw = $urandom_range(MAX_SCALE + 1, 15);
        else if (r < 85)
            s_raw = $urandom_range(1, 3);
        else
            s_raw = $urandom_range(4, MAX_SCALE);
        if ($urandom_range(99) < 4)
        begin
            w_raw = $urandom_range(MAX_SPRITE_DIM, 127);
            h_raw = $urandom_range(0, 1);
            s_raw = 1;
        end
        else
        begin
            w_raw = ($urandom_range(99) < 6) ? 0 : $urandom_range(1, 6);
            h_raw = ($urandom_range(99) < 6) ? 0 : $urandom_range(1, 6);
        end
        r  = $urandom_range(99);
        sw = (r < 5) ? 0 : (r < 12) ? 1023 : $urandom_range(1, 300);
        r  = $urandom_range(99);
        sh = (r < 5) ? 0 : (r < 12) ? 1023 : $urandom_range(1, 300);
        x  = ($urandom_range(99) < 15) ? $urandom_range(0, 2047) : $urandom_range(0, sw + 16) - 16;
        y  = ($urandom_range(99) < 15) ? $urandom_range(0, 2047) : $urandom_range(0, sh + 16) - 16;
        set_reg(REG_DEST_X, x);
        set_reg(REG_DEST_Y, y);
        set_reg(REG_SPRITE_WIDTH, w_raw | ($urandom_range(0, 15) << DIM_W));
        set_reg(REG_SPRITE_HEIGHT, h_raw | ($urandom_range(0, 15) << DIM_W));
        set_reg(REG_SCALE_FACTOR, s_raw | ($urandom_range(0, 127) << SCALE_W));
        set_reg(REG_FB_WIDTH, sw | ($urandom_range(0, 1) << SCR_W));
        set_reg(REG_FB_HEIGHT, sh | ($urandom_range(0, 1) << SCR_W));
        if ($urandom_range(99) < 10)
            set_reg(UNUSED_INDEX, $urandom_range(0, 2047));
        end_writes();
    endtask

    task automatic test_random_sprites(input int idle, input int stall, input int items);
        int sent;
        int n;
        send_idle_pct  = idle;
        sink_stall_pct = stall;
        sent = 0;
        while (sent < items)
        begin
            random_setup();
            n = dim_used(m_width) * dim_used(m_height);
            // a cut-off sprite leaves the counters mid-sprite for the next setup
            if ($urandom_range(99) < 20)
                n = $urandom_range(1, n);
            send_pixels(n);
            settle();
            sent += n;
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        pix_ch.valid       = 1'b0;
        pix_ch.pixel_color = '0;
        m_dest_x           = CFG_RESET.dest_x;
        m_dest_y           = CFG_RESET.dest_y;
        m_width            = CFG_RESET.sprite_width;
        m_height           = CFG_RESET.sprite_height;
        m_scale            = CFG_RESET.scale_factor;
        m_scr_w            = CFG_RESET.fb_width;
        m_scr_h            = CFG_RESET.fb_height;
        src_col            = 0;
        src_row            = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_size_clamps();
        test_screen_edges();
        test_counter_restart();
        test_ignored_index();
        test_random_sprites(0, 0, 65);
        test_random_sprites(70, 0, 65);
        test_long_rows(38, 38);
        test_random_sprites(0, 70, 65);
        test_random_sprites(38, 38, 65);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_writes.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected writes never arrived", $time, pending_writes.size());
        end
        $display("covered %0d pixels, %0d write beats (%0d on screen, %0d clipped), %0d sprite ends",
                 n_pixels, n_beats, n_onscreen, n_beats - n_onscreen, n_sprite_ends);
        $display("scales 0..15, sprite sizes 0..127, screens 0..1023, four idle/stall mixes");
        if (errors == 0)
            $display("scaled_sprite_blitter_core regression: pass");
        else
            $display("scaled_sprite_blitter_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
